// ===== rtl/core/plst_pkg.sv =====
`timescale 1ns / 1ps

package plst_pkg;

  // Storage bound. The list never grows past LIMIT, the most items one listing may give.
  localparam int CAPACITY = 16;
  localparam int MAX_OUT  = 16;
  localparam int LIMIT    = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
  localparam int IDX_W    = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam int CNT_W    = $clog2(LIMIT + 1);

  localparam int KIND_W   = 3;
  localparam int POS_W    = 5;
  localparam int DATA_W   = 32;
  localparam int LEN_W    = 5;
  localparam int STAT_W   = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 40;

  typedef enum logic [KIND_W-1:0] {
    REQ_TAIL   = 3'd0,
    REQ_HEAD   = 3'd1,
    REQ_POS    = 3'd2,
    REQ_DELETE = 3'd3,
    REQ_LIST   = 3'd4
  } req_kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  // Broadcast to every cell; each cell compares sel_idx with its own place.
  typedef struct packed {
    cell_op_e               op;
    logic [IDX_W-1:0]       sel_idx;
  } cell_cmd_t;

endpackage

// ===== rtl/core/plst_cell.sv =====
`timescale 1ns / 1ps

module plst_cell (
  input  logic                            clk_i,
  input  logic [plst_pkg::IDX_W-1:0]      idx_i,
  input  plst_pkg::cell_cmd_t             cmd_i,
  input  logic signed [plst_pkg::DATA_W-1:0] new_value_i,
  input  logic signed [plst_pkg::DATA_W-1:0] left_i,
  input  logic signed [plst_pkg::DATA_W-1:0] right_i,
  input  logic signed [plst_pkg::DATA_W-1:0] head_i,
  output logic signed [plst_pkg::DATA_W-1:0] value_o
);
  import plst_pkg::*;

  logic signed [DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    unique case (cmd_i.op)
      OP_HOLD: value_d = value_q;
      OP_INSERT: begin
        if (idx_i > cmd_i.sel_idx) begin
          value_d = left_i;
        end else if (idx_i == cmd_i.sel_idx) begin
          value_d = new_value_i;
        end
      end
      OP_DELETE: begin
        if (idx_i >= cmd_i.sel_idx) begin
          value_d = right_i;
        end
      end
      OP_ROTATE: begin
        // The occupied part of the row turns by one place; the head wraps to the tail.
        if (idx_i == cmd_i.sel_idx) begin
          value_d = head_i;
        end else if (idx_i < cmd_i.sel_idx) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== rtl/core/positional_list_store.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// s_axis   in   s_axis_tvalid/tready    tdata: position, new_value; tuser: req_type
// m_axis   out  m_axis_tvalid/tready    tdata: status, entry_value, list_length;
//                                       tuser: has_entry; tlast: last_of_run
//
// Inserts and deletes shift every cell with its neighbor in parallel.
// A listing shows the entries one at a time, from the head, by turning the row of
// cells once around; the list is back in order when it ends.
// Reset clears the entry count and the output valid; cell contents are not reset.
// A stalled output holds the row; the input is taken whenever the output register is
// free or being drained and no listing is running.

module positional_list_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] position, [36:5] new_value, [39:37] zero
  input  logic [plst_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] req_type
  input  logic [plst_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [1:0] status, [33:2] entry_value, [38:34] list_length, [39] zero
  output logic [plst_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] has_entry
  output logic                            m_axis_tuser,
  output logic                            m_axis_tlast
);
  import plst_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_e;

  state_e                   state_q;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CNT_W-1:0]         list_idx_q;
  logic                     m_valid_q;
  status_e                  m_status_q;
  logic signed [DATA_W-1:0] m_entry_q;
  logic                     m_has_q;
  logic [LEN_W-1:0]         m_len_q;
  logic                     m_last_q;

  logic                     out_free;
  logic                     accept;
  req_kind_e                kind;
  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] new_value;
  logic                     full;
  logic                     pos_ok;
  logic [CNT_W-1:0]         count_m1;

  cell_cmd_t                cell_cmd;
  logic                     emit;
  status_e                  res_status;
  logic signed [DATA_W-1:0] res_entry;
  logic                     res_has;
  logic                     res_last;
  logic                     start_list;

  logic signed [DATA_W-1:0] cell_val [LIMIT];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign kind      = req_kind_e'(s_axis_tuser);
  assign pos       = s_axis_tdata[POS_W-1:0];
  assign new_value = s_axis_tdata[POS_W+DATA_W-1:POS_W];
  assign full      = count_q >= CNT_W'(LIMIT);
  assign pos_ok    = (pos != '0) && (8'(pos) <= 8'(count_q));
  assign count_m1  = count_q - CNT_W'(1);

  always_comb begin
    cell_cmd   = '{op: OP_HOLD, sel_idx: '0};
    count_d    = count_q;
    emit       = 1'b0;
    res_status = STAT_OK;
    res_entry  = '0;
    res_has    = 1'b0;
    res_last   = 1'b1;
    start_list = 1'b0;
    if (accept) begin
      unique case (kind)
        REQ_TAIL, REQ_HEAD, REQ_POS: begin
          emit = 1'b1;
          if (full) begin
            res_status = STAT_FULL;
          end else if (kind == REQ_TAIL) begin
            cell_cmd = '{op: OP_INSERT, sel_idx: count_q[IDX_W-1:0]};
            count_d  = count_q + CNT_W'(1);
          end else if (kind == REQ_HEAD) begin
            cell_cmd = '{op: OP_INSERT, sel_idx: '0};
            count_d  = count_q + CNT_W'(1);
          end else if (!pos_ok) begin
            res_status = STAT_BADPOS;
          end else begin
            cell_cmd = '{op: OP_INSERT, sel_idx: IDX_W'(pos - POS_W'(1))};
            count_d  = count_q + CNT_W'(1);
          end
        end
        REQ_DELETE: begin
          emit = 1'b1;
          if (!pos_ok) begin
            res_status = STAT_BADPOS;
          end else begin
            cell_cmd = '{op: OP_DELETE, sel_idx: IDX_W'(pos - POS_W'(1))};
            count_d  = count_q - CNT_W'(1);
          end
        end
        REQ_LIST: begin
          if (count_q == '0) begin
            emit = 1'b1;
          end else begin
            start_list = 1'b1;
          end
        end
        default: ;
      endcase
    end else if (state_q == ST_LIST && out_free) begin
      // Show the head cell, then turn the row so the next entry comes to the head.
      cell_cmd  = '{op: OP_ROTATE, sel_idx: count_m1[IDX_W-1:0]};
      emit      = 1'b1;
      res_entry = cell_val[0];
      res_has   = 1'b1;
      res_last  = (list_idx_q == count_m1);
    end
  end

  for (genvar g = 0; g < LIMIT; g++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[g-1];
    end
    if (g == LIMIT - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[g+1];
    end
    plst_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(g)),
      .cmd_i       (cell_cmd),
      .new_value_i (new_value),
      .left_i      (left),
      .right_i     (right),
      .head_i      (cell_val[0]),
      .value_o     (cell_val[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      list_idx_q <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      if (start_list) begin
        state_q    <= ST_LIST;
        list_idx_q <= '0;
      end else if (state_q == ST_LIST && out_free) begin
        if (res_last) begin
          state_q <= ST_IDLE;
        end
        list_idx_q <= list_idx_q + CNT_W'(1);
      end
      if (emit) begin
        m_valid_q  <= 1'b1;
        m_status_q <= res_status;
        m_entry_q  <= res_entry;
        m_has_q    <= res_has;
        m_len_q    <= LEN_W'(count_d);
        m_last_q   <= res_last;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_len_q, m_entry_q, m_status_q};
  assign m_axis_tuser  = m_has_q;
  assign m_axis_tlast  = m_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(LIMIT))
    else $error("entry count beyond capacity");

  a_list_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |=> (count_q == $past(count_q)))
    else $error("entry count changed during a listing");

  a_entry_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_has_q) |-> (m_status_q == STAT_OK))
    else $error("listed entry with bad status");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_has_q) |-> m_last_q)
    else $error("non-listing result not marked last");

  a_list_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LIST) |-> (list_idx_q < count_q))
    else $error("listing index past the end of the list");

endmodule

// ===== verif/positional_list_store_tb.sv =====
`timescale 1ns / 1ps

module positional_list_store_tb;
  import plst_pkg::*;

  localparam int ITEM_TARGET    = 230;
  localparam int PRESSURE_AFTER = 60;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 3 * LIMIT + 10;
  localparam int QUIET_LIMIT    = 2000;

  // Request kinds that the block ignores.
  localparam logic [KIND_W-1:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] REQ_UNUSED_HI = 3'd7;

  localparam int POS_MAX   = (1 << POS_W) - 1;
  localparam int VAL_LSB   = STAT_W;
  localparam int LEN_LSB   = STAT_W + DATA_W;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } list_request_t;

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic              has;
    logic [LEN_W-1:0]  len;
    logic              last;
  } list_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  list_request_t     pending_requests[$];
  list_result_t      expected_results[$];
  logic [DATA_W-1:0] model_cells[$];

  list_request_t cur_req;
  list_result_t  want;
  int            gen_len;
  int            items_queued;
  int            error_count;
  int            results_seen;
  int            kind_hits[8];
  int            full_seen;
  int            badpos_seen;
  int            longest_listing;
  int            tx_idle, tx_calm, rx_stall, rx_calm, hold_left;
  bit            pressure_done;
  int            quiet_cycles;

  positional_list_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, a few long ones, and now and then a calm run with none.
  function automatic int next_idle(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(10, 30);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_result(status_e st, logic [DATA_W-1:0] val, logic has,
                                      logic last);
    list_result_t r;
    r.status = st;
    r.value  = val;
    r.has    = has;
    r.len    = LEN_W'(model_cells.size());
    r.last   = last;
    expected_results.push_back(r);
  endfunction

  // Applies one accepted request to the list copy and queues the results it causes.
  function automatic void predict_list_request(list_request_t req);
    int      n;
    status_e st;
    n  = model_cells.size();
    st = STAT_OK;
    kind_hits[req.kind]++;
    if (req.kind == REQ_TAIL || req.kind == REQ_HEAD || req.kind == REQ_POS) begin
      if (n >= LIMIT) begin
        st = STAT_FULL;
      end else if (req.kind == REQ_TAIL) begin
        model_cells.push_back(req.value);
      end else if (req.kind == REQ_HEAD) begin
        model_cells.push_front(req.value);
      end else if (req.pos < 1 || req.pos > n) begin
        st = STAT_BADPOS;
      end else begin
        model_cells.insert(req.pos - 1, req.value);
      end
      push_result(st, '0, 1'b0, 1'b1);
    end else if (req.kind == REQ_DELETE) begin
      if (req.pos < 1 || req.pos > n) st = STAT_BADPOS;
      else model_cells.delete(req.pos - 1);
      push_result(st, '0, 1'b0, 1'b1);
    end else if (req.kind == REQ_LIST) begin
      if (n == 0) push_result(STAT_OK, '0, 1'b0, 1'b1);
      for (int i = 0; i < n; i++) push_result(STAT_OK, model_cells[i], 1'b1, i == n - 1);
      if (n > longest_listing) longest_listing = n;
    end
    if (st == STAT_FULL) full_seen++;
    if (st == STAT_BADPOS) badpos_seen++;
  endfunction

  // Queues a request and keeps a rough length so that positions can be aimed.
  task automatic queue_request(logic [KIND_W-1:0] kind, int pos, logic [DATA_W-1:0] val);
    list_request_t req;
    req.kind  = kind;
    req.pos   = POS_W'(pos);
    req.value = val;
    pending_requests.push_back(req);
    if (kind <= REQ_LIST) items_queued++;
    if ((kind == REQ_TAIL || kind == REQ_HEAD) && gen_len < LIMIT) gen_len++;
    if (kind == REQ_POS && gen_len < LIMIT && req.pos >= 1 && req.pos <= gen_len) gen_len++;
    if (kind == REQ_DELETE && req.pos >= 1 && req.pos <= gen_len) gen_len--;
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_list_request(cur_req);
        tx_idle = next_idle(tx_calm);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_idle > 0) begin
          tx_idle--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          s_axis_tdata  <= {3'b000, cur_req.value, cur_req.pos};
          s_axis_tuser  <= cur_req.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          // tdata: [1:0] status, [33:2] entry_value, [38:34] list_length.
          check_field("status", DATA_W'(want.status), DATA_W'(m_axis_tdata[STAT_W-1:0]));
          check_field("entry_value", want.value, m_axis_tdata[VAL_LSB +: DATA_W]);
          check_field("has_entry", DATA_W'(want.has), DATA_W'(m_axis_tuser));
          check_field("list_length", DATA_W'(want.len), DATA_W'(m_axis_tdata[LEN_LSB +: LEN_W]));
          check_field("last_of_run", DATA_W'(want.last), DATA_W'(m_axis_tlast));
        end
        rx_stall = next_idle(rx_calm);
      end
      // One long hold-off lets the block fill up and stall its input.
      if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("positional_list_store_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int scenario;
    int n;
    logic [KIND_W-1:0] k;

    // Directed part: empty list, bad positions, field extremes, ignored kinds.
    queue_request(REQ_LIST, 0, '0);
    queue_request(REQ_DELETE, 1, '0);
    queue_request(REQ_POS, 1, 32'h1234_5678);
    queue_request(REQ_TAIL, 0, 32'h8000_0000);
    queue_request(REQ_HEAD, POS_MAX, 32'h7FFF_FFFF);
    queue_request(REQ_POS, 0, 32'h5555_5555);
    queue_request(REQ_POS, 2, 32'hFFFF_FFFF);
    queue_request(REQ_POS, 3, 32'h0000_0000);
    queue_request(REQ_POS, 5, 32'hAAAA_AAAA);
    queue_request(REQ_POS, 16, 32'h0F0F_0F0F);
    queue_request(REQ_DELETE, 0, '0);
    queue_request(REQ_DELETE, POS_MAX, 32'hFFFF_FFFF);
    queue_request(REQ_UNUSED_LO, 1, 32'hDEAD_BEEF);
    queue_request(REQ_UNUSED_LO + 3'd1, 2, 32'h0000_0001);
    queue_request(REQ_UNUSED_HI, POS_MAX, 32'hFFFF_FFFF);
    queue_request(REQ_LIST, 16, 32'hFFFF_FFFF);
    queue_request(REQ_DELETE, 4, '0);
    queue_request(REQ_DELETE, 1, '0);
    queue_request(REQ_LIST, 0, '0);

    // First random run fills the list to capacity and pushes past it.
    while (gen_len < LIMIT) queue_request(REQ_TAIL, $urandom_range(0, POS_MAX), pick_value());
    queue_request(REQ_HEAD, 0, pick_value());
    queue_request(REQ_POS, 1, pick_value());
    queue_request(REQ_TAIL, 0, pick_value());
    queue_request(REQ_LIST, 0, '0);

    while (items_queued < ITEM_TARGET) begin
      scenario = $urandom_range(0, 99);
      if (scenario < 30) begin
        n = $urandom_range(1, LIMIT - gen_len + 2);
        repeat (n) begin
          k = KIND_W'($urandom_range(REQ_TAIL, REQ_POS));
          queue_request(k, (gen_len == 0) ? 1 : $urandom_range(1, gen_len), pick_value());
        end
        queue_request(REQ_LIST, 0, '0);
      end else if (scenario < 55) begin
        n = $urandom_range(1, gen_len + 1);
        repeat (n) queue_request(REQ_DELETE, $urandom_range(1, (gen_len > 0) ? gen_len : 1),
                                 pick_value());
        queue_request(REQ_LIST, 0, '0);
      end else if (scenario < 85) begin
        queue_request(KIND_W'($urandom_range(REQ_TAIL, REQ_LIST)),
                      $urandom_range(0, gen_len + 1), pick_value());
      end else begin
        queue_request(KIND_W'($urandom_range(0, REQ_UNUSED_HI)), $urandom_range(0, POS_MAX),
                      pick_value());
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Requests: %0d tail, %0d head, %0d at position, %0d delete, %0d list, %0d ignored.",
             kind_hits[REQ_TAIL], kind_hits[REQ_HEAD], kind_hits[REQ_POS],
             kind_hits[REQ_DELETE], kind_hits[REQ_LIST],
             kind_hits[5] + kind_hits[6] + kind_hits[7]);
    $display("Checked %0d result items; %0d full, %0d bad position, longest listing %0d.",
             results_seen, full_seen, badpos_seen, longest_listing);
    if (error_count == 0) begin
      $display("positional_list_store_tb: clean");
    end else begin
      $display("positional_list_store_tb: errors");
    end
    $finish;
  end

endmodule
